// ===== design/sspd_pkg.sv =====
// Shared types, constants and CRC function for the status packet deframer.
package sspd_pkg;

    localparam int unsigned MAX_PACKET_LEN_DEF = 1024;

    localparam logic [23:0] HDR_PATTERN = 24'hFFFFFD;
    localparam logic [15:0] CRC_POLY    = 16'h8005;
    localparam logic [7:0]  STUFF_BYTE  = 8'hFD;
    localparam logic [7:0]  MAX_ID      = 8'hFC;
    localparam logic [7:0]  STATUS_INST = 8'h55;
    localparam logic [7:0]  RESERVED_VAL = 8'h00;
    localparam logic [15:0] MIN_LEN     = 16'd4;

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    localparam logic KIND_BODY   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_SUCCESS = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_CORRUPT = 2'd2;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_RESERVED,
        PH_ID,
        PH_LEN_L,
        PH_LEN_H,
        PH_INST,
        PH_BODY,
        PH_CRC_L,
        PH_CRC_H
    } t_phase;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  rx_byte;
    } t_req;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  body_byte;
        logic [1:0]  status_code;
        logic [7:0]  device_id;
        logic [7:0]  device_error;
        logic [10:0] body_length;
        logic        last;
    } t_result;

    function automatic logic [15:0] f_crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    localparam logic [15:0] CRC_HDR =
        f_crc_byte(f_crc_byte(f_crc_byte(16'h0000, 8'hFF), 8'hFF), 8'hFD);

endpackage

// ===== design/sspd_in_reg.sv =====
// Input word register of the status packet deframer.
module sspd_in_reg
    import sspd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    input  logic i_take,
    output logic o_valid,
    output t_req o_req
);

    logic r_valid;
    t_req r_req;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

// ===== design/sspd_core.sv =====
// Header hunt, field checks, CRC, destuffing and status generation.
module sspd_core
    import sspd_pkg::*;
#(
    parameter int unsigned MAX_PACKET_LEN = MAX_PACKET_LEN_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_req    i_req,
    input  logic    i_out_free,
    output logic    o_take,
    output logic    o_emit,
    output t_result o_result
);

    localparam int unsigned LEN_W = $clog2(MAX_PACKET_LEN + 1);

    t_phase           r_phase, n_phase;
    logic [23:0]      r_recent, n_recent;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic [LEN_W-1:0] r_decl, n_decl;
    logic [LEN_W-1:0] r_dlen, n_dlen;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_len_lo, n_len_lo;
    logic [7:0]       r_crc_lo, n_crc_lo;
    logic [7:0]       r_id, n_id;
    logic [7:0]       r_err, n_err;
    logic             r_any, n_any;

    logic [7:0]       b;
    logic [23:0]      shifted;
    logic [15:0]      crc_next;
    logic [15:0]      full_len;
    logic [15:0]      dlen16;
    logic [LEN_W-1:0] pos_inc;

    assign o_take   = i_valid && i_out_free;
    assign b        = i_req.rx_byte;
    assign shifted  = {r_recent[15:0], b};
    assign crc_next = f_crc_byte(r_crc, b);
    assign full_len = {b, r_len_lo};
    assign dlen16   = 16'(r_dlen);
    assign pos_inc  = r_pos + LEN_W'(1);

    always_comb begin
        n_phase  = r_phase;
        n_recent = r_recent;
        n_pos    = r_pos;
        n_decl   = r_decl;
        n_dlen   = r_dlen;
        n_crc    = r_crc;
        n_len_lo = r_len_lo;
        n_crc_lo = r_crc_lo;
        n_id     = r_id;
        n_err    = r_err;
        n_any    = r_any;
        o_emit   = 1'b0;
        o_result = '0;

        if (i_req.req_type == REQ_TIMEOUT) begin
            o_emit               = 1'b1;
            o_result.result_kind = KIND_STATUS;
            o_result.status_code = r_any ? ST_CORRUPT : ST_TIMEOUT;
            o_result.last        = 1'b1;
            n_phase              = PH_HUNT;
            n_recent             = '0;
            n_any                = 1'b0;
        end else begin
            n_any    = 1'b1;
            n_recent = shifted;
            unique case (r_phase)
                PH_HUNT: begin
                    if (shifted == HDR_PATTERN) begin
                        n_crc   = CRC_HDR;
                        n_phase = PH_RESERVED;
                    end
                end
                PH_RESERVED: begin
                    if (b != RESERVED_VAL) begin
                        n_phase  = PH_HUNT;
                        n_recent = '0;
                    end else begin
                        n_crc   = crc_next;
                        n_phase = PH_ID;
                    end
                end
                PH_ID: begin
                    if (b > MAX_ID) begin
                        n_phase  = PH_HUNT;
                        n_recent = '0;
                    end else begin
                        n_id    = b;
                        n_crc   = crc_next;
                        n_phase = PH_LEN_L;
                    end
                end
                PH_LEN_L: begin
                    n_len_lo = b;
                    n_crc    = crc_next;
                    n_phase  = PH_LEN_H;
                end
                PH_LEN_H: begin
                    if (full_len < MIN_LEN ||
                        {1'b0, full_len} > 17'(MAX_PACKET_LEN)) begin
                        n_phase  = PH_HUNT;
                        n_recent = '0;
                    end else begin
                        n_decl  = full_len[LEN_W-1:0];
                        n_dlen  = full_len[LEN_W-1:0];
                        n_crc   = crc_next;
                        n_phase = PH_INST;
                    end
                end
                PH_INST: begin
                    if (b != STATUS_INST) begin
                        n_phase  = PH_HUNT;
                        n_recent = '0;
                    end else begin
                        n_crc   = crc_next;
                        n_pos   = '0;
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_crc = crc_next;
                    if (r_pos == '0) begin
                        n_err = b;
                    end
                    n_pos = pos_inc;
                    if (pos_inc >= r_decl - LEN_W'(3)) begin
                        n_phase = PH_CRC_L;
                    end
                    if (r_recent == HDR_PATTERN && b == STUFF_BYTE) begin
                        n_dlen = r_dlen - LEN_W'(1);
                    end else begin
                        o_emit               = 1'b1;
                        o_result.result_kind = KIND_BODY;
                        o_result.body_byte   = b;
                    end
                end
                PH_CRC_L: begin
                    n_crc_lo = b;
                    n_phase  = PH_CRC_H;
                end
                PH_CRC_H: begin
                    o_emit                = 1'b1;
                    o_result.result_kind  = KIND_STATUS;
                    o_result.status_code  = ({b, r_crc_lo} == r_crc) ? ST_SUCCESS : ST_CORRUPT;
                    o_result.device_id    = r_id;
                    o_result.device_error = r_err;
                    o_result.body_length  = dlen16[10:0];
                    o_result.last         = 1'b1;
                    n_phase               = PH_HUNT;
                    n_recent              = '0;
                    n_any                 = 1'b0;
                end
                default: begin
                    n_phase  = PH_HUNT;
                    n_recent = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_recent <= '0;
            r_pos    <= '0;
            r_decl   <= '0;
            r_dlen   <= '0;
            r_crc    <= '0;
            r_len_lo <= '0;
            r_crc_lo <= '0;
            r_id     <= '0;
            r_err    <= '0;
            r_any    <= 1'b0;
        end else if (o_take) begin
            r_phase  <= n_phase;
            r_recent <= n_recent;
            r_pos    <= n_pos;
            r_decl   <= n_decl;
            r_dlen   <= n_dlen;
            r_crc    <= n_crc;
            r_len_lo <= n_len_lo;
            r_crc_lo <= n_crc_lo;
            r_id     <= n_id;
            r_err    <= n_err;
            r_any    <= n_any;
        end
    end

endmodule

// ===== design/sspd_out_reg.sv =====
// Result word register of the status packet deframer.
module sspd_out_reg
    import sspd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== design/servo_status_packet_deframer_unit.sv =====
// Top level of the servo status packet deframer.
// Path: an accepted word is held in the input register; the core works on it combinationally and
// its result is loaded into the output register, from which the receiver takes it.
// Throughput: one word per cycle; each word is handled in a single pass between the input
// register and the result register; a result held by the receiver stalls the input.
// Reset: synchronous, active low; clears control state and returns to header hunt.
module servo_status_packet_deframer_unit
    import sspd_pkg::*;
#(
    parameter int unsigned MAX_PACKET_LEN = MAX_PACKET_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [7:0]  o_body_byte,
    output logic [1:0]  o_status_code,
    output logic [7:0]  o_device_id,
    output logic [7:0]  o_device_error,
    output logic [10:0] o_body_length,
    output logic        o_last
);

    t_req    in_req;
    t_req    held_req;
    logic    held_valid;
    logic    take;
    logic    out_free;
    logic    emit;
    t_result core_result;
    t_result out_result;

    assign in_req.req_type = i_req_type;
    assign in_req.rx_byte  = i_rx_byte;

    sspd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (in_req),
        .i_take  (take),
        .o_valid (held_valid),
        .o_req   (held_req)
    );

    sspd_core #(
        .MAX_PACKET_LEN (MAX_PACKET_LEN)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (held_valid),
        .i_req      (held_req),
        .i_out_free (out_free),
        .o_take     (take),
        .o_emit     (emit),
        .o_result   (core_result)
    );

    sspd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && emit),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_result_kind  = out_result.result_kind;
    assign o_body_byte    = out_result.body_byte;
    assign o_status_code  = out_result.status_code;
    assign o_device_id    = out_result.device_id;
    assign o_device_error = out_result.device_error;
    assign o_body_length  = out_result.body_length;
    assign o_last         = out_result.last;

endmodule

// ===== bench/sspd_deframer_checker.sv =====
`timescale 1ns / 100ps
// Checker for the status packet deframer: predicts results from accepted words, compares in order.
module sspd_deframer_checker
    import sspd_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_PACKET_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_result_kind,
    input  logic [7:0]  i_body_byte,
    input  logic [1:0]  i_status_code,
    input  logic [7:0]  i_device_id,
    input  logic [7:0]  i_device_error,
    input  logic [10:0] i_body_length,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    t_phase      phase;
    logic [23:0] recent;
    logic [15:0] body_pos;
    logic [15:0] decl_len;
    logic [15:0] destuffed_len;
    logic [15:0] crc_acc;
    logic [7:0]  crc_low;
    logic [7:0]  pkt_id;
    logic [7:0]  err_byte;
    logic        seen_byte;
    t_result     expected_q[$];

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("kind=%0d byte=%02h status=%0d id=%02h err=%02h len=%0d last=%0d",
                         r.result_kind, r.body_byte, r.status_code, r.device_id,
                         r.device_error, r.body_length, r.last);
    endfunction

    task automatic rehunt();
        phase  = PH_HUNT;
        recent = '0;
    endtask

    task automatic expect_result(input t_result r);
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic push_status(input logic [1:0] code, input logic [7:0] id,
                               input logic [7:0] er, input logic [10:0] len);
        t_result r;
        r              = '0;
        r.result_kind  = KIND_STATUS;
        r.status_code  = code;
        r.device_id    = id;
        r.device_error = er;
        r.body_length  = len;
        r.last         = 1'b1;
        expect_result(r);
    endtask

    task automatic reset_model();
        phase         = PH_HUNT;
        recent        = '0;
        body_pos      = '0;
        decl_len      = '0;
        destuffed_len = '0;
        crc_acc       = '0;
        crc_low       = '0;
        pkt_id        = '0;
        err_byte      = '0;
        seen_byte     = 1'b0;
        expected_q.delete();
    endtask

    task automatic predict_word(input logic req, input logic [7:0] b);
        logic [23:0] prev;
        logic        stuffed;
        t_result     r;
        prev = recent;
        r    = '0;
        if (req == REQ_TIMEOUT) begin
            push_status(seen_byte ? ST_CORRUPT : ST_TIMEOUT, 8'h00, 8'h00, 11'd0);
            rehunt();
            seen_byte = 1'b0;
        end else begin
            seen_byte = 1'b1;
            recent    = {prev[15:0], b};
            case (phase)
                PH_HUNT: begin
                    if (recent == HDR_PATTERN) begin
                        crc_acc = crc16_step(crc16_step(crc16_step(16'h0000, HDR_PATTERN[23:16]),
                                                        HDR_PATTERN[15:8]), HDR_PATTERN[7:0]);
                        phase   = PH_RESERVED;
                    end
                end
                PH_RESERVED: begin
                    if (b != RESERVED_VAL) begin
                        rehunt();
                    end else begin
                        crc_acc = crc16_step(crc_acc, b);
                        phase   = PH_ID;
                    end
                end
                PH_ID: begin
                    if (b > MAX_ID) begin
                        rehunt();
                    end else begin
                        pkt_id  = b;
                        crc_acc = crc16_step(crc_acc, b);
                        phase   = PH_LEN_L;
                    end
                end
                PH_LEN_L: begin
                    decl_len = {8'h00, b};
                    crc_acc  = crc16_step(crc_acc, b);
                    phase    = PH_LEN_H;
                end
                PH_LEN_H: begin
                    decl_len[15:8] = b;
                    if (decl_len < MIN_LEN || decl_len > MAX_LEN) begin
                        rehunt();
                    end else begin
                        destuffed_len = decl_len;
                        crc_acc       = crc16_step(crc_acc, b);
                        phase         = PH_INST;
                    end
                end
                PH_INST: begin
                    if (b != STATUS_INST) begin
                        rehunt();
                    end else begin
                        crc_acc  = crc16_step(crc_acc, b);
                        body_pos = '0;
                        phase    = PH_BODY;
                    end
                end
                PH_BODY: begin
                    stuffed = (prev == HDR_PATTERN) && (b == STUFF_BYTE);
                    crc_acc = crc16_step(crc_acc, b);
                    if (body_pos == 16'd0) begin
                        err_byte = b;
                    end
                    body_pos = body_pos + 16'd1;
                    if (body_pos >= decl_len - 16'd3) begin
                        phase = PH_CRC_L;
                    end
                    if (stuffed) begin
                        destuffed_len = destuffed_len - 16'd1;
                    end else begin
                        r.result_kind = KIND_BODY;
                        r.body_byte   = b;
                        expect_result(r);
                    end
                end
                PH_CRC_L: begin
                    crc_low = b;
                    phase   = PH_CRC_H;
                end
                PH_CRC_H: begin
                    push_status(({b, crc_low} == crc_acc) ? ST_SUCCESS : ST_CORRUPT,
                                pkt_id, err_byte, destuffed_len[10:0]);
                    rehunt();
                    seen_byte = 1'b0;
                end
                default: begin
                    rehunt();
                end
            endcase
        end
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.result_kind  = i_result_kind;
        got.body_byte    = i_body_byte;
        got.status_code  = i_status_code;
        got.device_id    = i_device_id;
        got.device_error = i_device_error;
        got.body_length  = i_body_length;
        got.last         = i_last;
        if (expected_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("%0t: result with nothing expected: %s", $realtime, show(got));
            end
        end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
                o_fail_count++;
                if (o_fail_count <= 10) begin
                    $display("%0t: mismatch expected %s", $realtime, show(want));
                    $display("%0t:          actual   %s", $realtime, show(got));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_in_valid && i_in_ready) begin
                predict_word(i_req_type, i_rx_byte);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== bench/servo_status_packet_deframer_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: feeds framed, stuffed, broken and noisy byte streams and gives the verdict.
module servo_status_packet_deframer_unit_tb;
    import sspd_pkg::*;

    localparam int BODY_PLAIN  = 0;
    localparam int BODY_STUFFY = 1;
    localparam int BODY_NO_FD  = 2;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        req_type  = REQ_BYTE;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        res_kind;
    logic [7:0]  res_byte;
    logic [1:0]  res_status;
    logic [7:0]  res_id;
    logic [7:0]  res_error;
    logic [10:0] res_length;
    logic        res_last;

    int          fail_count;
    int          pending;
    bit          quiet     = 1'b0;
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_cnt  = 0;
    int          sent_count = 0;
    logic [7:0]  body_q[$];
    logic [7:0]  frame_q[$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    servo_status_packet_deframer_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_req_type     (req_type),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_result_kind  (res_kind),
        .o_body_byte    (res_byte),
        .o_status_code  (res_status),
        .o_device_id    (res_id),
        .o_device_error (res_error),
        .o_body_length  (res_length),
        .o_last         (res_last)
    );

    sspd_deframer_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_req_type     (req_type),
        .i_rx_byte      (rx_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_result_kind  (res_kind),
        .i_body_byte    (res_byte),
        .i_status_code  (res_status),
        .i_device_id    (res_id),
        .i_device_error (res_error),
        .i_body_length  (res_length),
        .i_last         (res_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge clk) begin
        if (hold_cnt != 0) begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            out_ready <= 1'b0;
            hold_cnt  <= 400;
            hold_done <= 1'b1;
        end else if (quiet) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 23);
        end
    end

    function automatic logic [15:0] frame_crc(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        repeat (8) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_byte(input int mode);
        logic [7:0] b;
        b = 8'($urandom);
        if (mode == BODY_STUFFY) begin
            case ($urandom_range(4))
                0, 1:    b = 8'hFF;
                2:       b = STUFF_BYTE;
                3:       b = 8'h00;
                default: b = 8'($urandom);
            endcase
        end else if (mode == BODY_NO_FD) begin
            b = b & 8'hF7;
        end
        return b;
    endfunction

    function automatic logic [7:0] pick_id();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return MAX_ID;
            default: return 8'($urandom_range(MAX_ID));
        endcase
    endfunction

    task automatic send_word(input logic req, input logic [7:0] b);
        if (!quiet && $urandom_range(99) < 23) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 23) begin
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        req_type <= req;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
    endtask

    task automatic send_timeout();
        send_word(REQ_TIMEOUT, 8'($urandom));
        sent_count++;
    endtask

    task automatic send_frame(input int upto);
        for (int i = 0; i < upto; i++) begin
            send_word(REQ_BYTE, frame_q[i]);
        end
        sent_count += upto;
    endtask

    task automatic append_frame(input logic [7:0] b);
        frame_q.insert(frame_q.size(), b);
    endtask

    task automatic fill_body(input int n_param, input int mode);
        body_q.delete();
        repeat (n_param + 1) begin
            body_q.insert(body_q.size(), pick_byte(mode));
        end
    endtask

    task automatic build_frame(input logic [7:0] id, input bit crc_bad);
        logic [7:0]  raw[$];
        logic [15:0] crc;
        logic [15:0] len;
        int          k;
        foreach (body_q[i]) begin
            raw.insert(raw.size(), body_q[i]);
            k = raw.size();
            if (k >= 3 && {raw[k-3], raw[k-2], raw[k-1]} == HDR_PATTERN) begin
                raw.insert(raw.size(), STUFF_BYTE);
            end
        end
        len = 16'(raw.size() + 3);
        frame_q.delete();
        append_frame(HDR_PATTERN[23:16]);
        append_frame(HDR_PATTERN[15:8]);
        append_frame(HDR_PATTERN[7:0]);
        append_frame(RESERVED_VAL);
        append_frame(id);
        append_frame(len[7:0]);
        append_frame(len[15:8]);
        append_frame(STATUS_INST);
        foreach (raw[i]) begin
            append_frame(raw[i]);
        end
        crc = 16'h0000;
        foreach (frame_q[i]) begin
            crc = frame_crc(crc, frame_q[i]);
        end
        if (crc_bad) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
        end
        append_frame(crc[7:0]);
        append_frame(crc[15:8]);
    endtask

    task automatic small_packet(input int mode, input bit crc_bad);
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(8);
        fill_body(n, mode);
        build_frame(pick_id(), crc_bad);
    endtask

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int          r;
        int          wait_cnt;
        logic [15:0] bad_len;
        logic [7:0]  bad_inst;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // timeout with nothing received, then a stuffed packet at the top ID
        send_timeout();
        body_q.delete();
        body_q.insert(body_q.size(), 8'hFF);
        body_q.insert(body_q.size(), 8'hFF);
        body_q.insert(body_q.size(), STUFF_BYTE);
        build_frame(MAX_ID, 1'b0);
        send_frame(frame_q.size());
        // timeout after a stray byte, then a header rejected on its ID
        send_word(REQ_BYTE, 8'h00);
        send_timeout();
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'hFD);
        send_word(REQ_BYTE, RESERVED_VAL);
        send_word(REQ_BYTE, 8'hFD);
        send_timeout();

        while (sent_count < 540) begin
            quiet = (sent_count >= 360 && sent_count < 440);
            if (sent_count >= 240) begin
                hold_req <= 1'b1;
            end
            r = $urandom_range(99);
            if (r < 45) begin
                small_packet($urandom_range(1) ? BODY_STUFFY : BODY_PLAIN, 1'b0);
                send_frame(frame_q.size());
            end else if (r < 55) begin
                small_packet($urandom_range(1) ? BODY_STUFFY : BODY_PLAIN, 1'b1);
                send_frame(frame_q.size());
            end else if (r < 67) begin
                small_packet(BODY_PLAIN, 1'b0);
                case ($urandom_range(3))
                    0: frame_q[3] = 8'(1 + $urandom_range(254));
                    1: frame_q[4] = 8'(253 + $urandom_range(2));
                    2: begin
                        case ($urandom_range(2))
                            0:       bad_len = 16'($urandom_range(3));
                            1:       bad_len = 16'hFFFF;
                            default: bad_len = 16'($urandom_range(16'hFFFF,
                                                                  MAX_PACKET_LEN_DEF + 1));
                        endcase
                        frame_q[5] = bad_len[7:0];
                        frame_q[6] = bad_len[15:8];
                    end
                    default: begin
                        bad_inst = 8'($urandom);
                        if (bad_inst == STATUS_INST) begin
                            bad_inst = ~bad_inst;
                        end
                        frame_q[7] = bad_inst;
                    end
                endcase
                send_frame(frame_q.size());
            end else if (r < 75) begin
                small_packet(BODY_STUFFY, 1'b0);
                send_frame($urandom_range(frame_q.size() - 1, 1));
                send_timeout();
            end else if (r < 80) begin
                send_timeout();
            end else if (r < 90) begin
                repeat ($urandom_range(6, 1)) begin
                    send_word(REQ_BYTE,
                              $urandom_range(1) ? 8'($urandom) : pick_byte(BODY_STUFFY));
                end
            end else begin
                fill_body($urandom_range(30, 4), BODY_STUFFY);
                build_frame(pick_id(), 1'b0);
                send_frame(frame_q.size());
            end
        end
        quiet = 1'b0;

        // header at the largest accepted length: body bytes flow until a timeout ends it
        fill_body(MAX_PACKET_LEN_DEF - 4, BODY_NO_FD);
        build_frame(pick_id(), 1'b0);
        send_frame(20);
        send_timeout();
        small_packet(BODY_STUFFY, 1'b0);
        send_frame(frame_q.size());
        in_valid <= 1'b0;

        wait_cnt = 0;
        @(negedge clk);
        while (pending != 0 && wait_cnt < 5000) begin
            @(negedge clk);
            wait_cnt++;
        end
        if (pending != 0) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            repeat (10) @(negedge clk);
            if (fail_count == 0 && pending == 0) begin
                $display("[ OK ] regression clean");
            end else begin
                $display("[FAIL] regression broken");
            end
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
design/sspd_pkg.sv
design/sspd_in_reg.sv
design/sspd_core.sv
design/sspd_out_reg.sv
design/servo_status_packet_deframer_unit.sv
bench/sspd_deframer_checker.sv
bench/servo_status_packet_deframer_unit_tb.sv
